### sv/batch_job_scheduler_metrics_assert.svh
// assertion macros for the scheduler checker
`ifndef BATCH_JOB_SCHEDULER_METRICS_ASSERT_SVH
`define BATCH_JOB_SCHEDULER_METRICS_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define BJS_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define BJS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### sv/bjs_pkg.sv
package bjs_pkg;

   localparam int unsigned TimeWidth  = 14;
   localparam int unsigned FracWidth  = 22;
   localparam logic [13:0] TimeMax    = 14'h3fff;

   localparam logic [1:0] PolicyFcfs = 2'd0;
   localparam logic [1:0] PolicySjf  = 2'd1;
   localparam logic [1:0] PolicyHrrn = 2'd2;

   typedef struct packed {
      logic [11:0] arrival_time;
      logic [7:0]  service_time;
      logic        last_job;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]  job_index;
      logic [13:0] start_time;
      logic [13:0] finish_time;
      logic [13:0] turnaround;
      logic [21:0] weighted_turnaround;
      logic [21:0] average_turnaround;
      logic [21:0] average_weighted;
      logic        overflow;
      logic        last_result;
   } rsp_payload_type;

   // request/answer of the shared divider
   typedef struct packed {
      logic        start;
      logic [29:0] dividend;
      logic [7:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [29:0] quotient;
   } div_rsp_type;

endpackage

### sv/bjs_divider.sv
module bjs_divider
   import bjs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [29:0] quot_ff, quot_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[7:0], quot_ff[29]};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 5'd29;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[28:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[28:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

### sv/bjs_job_store.sv
module bjs_job_store
   import bjs_pkg::*;
#(
   parameter int unsigned Depth = 32,
   parameter int unsigned AddrWidth = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [11:0]          wr_arrival,
   input  logic [7:0]           wr_service,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [11:0]          rd_arrival,
   output logic [7:0]           rd_service
);

   logic [19:0] mem [Depth];
   logic [19:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_arrival, wr_service};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_arrival = rd_ff[19:8];
   assign rd_service = rd_ff[7:0];

endmodule

### sv/batch_job_scheduler_metrics.sv
// channel  direction  payload           handshake
// req      in         req_payload_type  req_valid / req_stall
// rsp      out        rsp_payload_type  rsp_valid / rsp_stall
// csr      in         policy [1:0]      csr_write
// loading beats are accepted only in the load state; a closing beat starts scheduling
// each result takes two scans of the job memory (earliest arrival, then choice),
// two setup states (StRun, StRead), a division and an output state
// the last result adds two more divisions for the averages
// req_stall is high from the closing beat until the last result enters the output register
// rsp_stall holds the output register and the scheduler in its output state; reset is synchronous, active high
module batch_job_scheduler_metrics
   import bjs_pkg::*;
#(
   parameter int unsigned MAX_JOBS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic [1:0]      csr_policy
);

   localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int unsigned CW = $clog2(MAX_JOBS + 1);

   localparam logic [3:0] StLoad  = 4'd0;
   localparam logic [3:0] StScanA = 4'd1;
   localparam logic [3:0] StScanB = 4'd2;
   localparam logic [3:0] StRead  = 4'd3;
   localparam logic [3:0] StRun   = 4'd4;
   localparam logic [3:0] StWt    = 4'd5;
   localparam logic [3:0] StAvgT  = 4'd6;
   localparam logic [3:0] StAvgW  = 4'd7;
   localparam logic [3:0] StOut   = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          policy_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [13:0]         now_ff, now_in;
   logic [19:0]         tsum_ff, tsum_in;
   logic [27:0]         wsum_ff, wsum_in;
   logic                ovf_ff, ovf_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       emitted_ff, emitted_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic [12:0]         early_ff, early_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       best_ff, best_in;
   logic [11:0]         best_arr_ff, best_arr_in;
   logic [7:0]          best_svc_ff, best_svc_in;
   logic [13:0]         fin_ff, fin_in;
   logic [13:0]         start_ff, start_in;
   logic [13:0]         ta_ff, ta_in;
   logic [21:0]         wt_ff, wt_in;
   logic [21:0]         avgt_ff, avgt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [AW-1:0] rd_addr;
   logic [11:0]   rd_arrival;
   logic [7:0]    rd_service;
   logic          accept;
   logic          store_wr;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   logic          cand;
   logic          better;
   logic [22:0]   ra, rb;
   logic [14:0]   fin_sum;
   logic [13:0]   now_pick;
   logic [7:0]    svc_fix;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != StLoad);
   assign svc_fix  = (req_payload.service_time == 8'd0) ? 8'd1 : req_payload.service_time;
   assign store_wr = accept && (count_ff < CW'(MAX_JOBS));

   bjs_job_store #(.Depth(MAX_JOBS), .AddrWidth(AW)) u_store (
      .clock      (clock),
      .wr_en      (store_wr),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_arrival (req_payload.arrival_time),
      .wr_service (svc_fix),
      .rd_addr    (rd_addr),
      .rd_arrival (rd_arrival),
      .rd_service (rd_service)
   );

   bjs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_addr = scan_ff[AW-1:0];

   // compare the entry just read against the running best
   always_comb begin
      cand = rd_vld_ff && !done_ff[rd_idx_ff] && ({2'b00, rd_arrival} <= now_ff);
      ra = ({9'd0, now_ff} - {11'd0, rd_arrival} + {15'd0, rd_service}) * {15'd0, best_svc_ff};
      rb = ({9'd0, now_ff} - {11'd0, best_arr_ff} + {15'd0, best_svc_ff}) * {15'd0, rd_service};
      better = rd_arrival < best_arr_ff;
      if (policy_ff == PolicySjf) begin
         if (rd_service != best_svc_ff) begin
            better = rd_service < best_svc_ff;
         end
      end else if (policy_ff == PolicyHrrn) begin
         if (ra != rb) begin
            better = ra > rb;
         end
      end
      now_pick = (now_ff < {1'b0, early_ff}) ? {1'b0, early_ff} : now_ff;
      fin_sum  = {1'b0, now_ff} + {7'd0, best_svc_ff};
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      tsum_in      = tsum_ff;
      wsum_in      = wsum_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      scan_in      = scan_ff;
      emitted_in   = emitted_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_ff[AW-1:0];
      early_in     = early_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_arr_in  = best_arr_ff;
      best_svc_in  = best_svc_ff;
      fin_in       = fin_ff;
      ta_in        = ta_ff;
      wt_in        = wt_ff;
      avgt_in      = avgt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      div_req      = '0;
      unique case (state_ff)
         StLoad: begin
            if (accept) begin
               if (count_ff < CW'(MAX_JOBS)) begin
                  count_in = count_ff + CW'(1);
                  done_in[count_ff[AW-1:0]] = 1'b0;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_job) begin
                  state_in   = StScanA;
                  scan_in    = '0;
                  early_in   = 13'h1fff;
                  emitted_in = '0;
               end
            end
         end
         // earliest arrival among pending jobs
         StScanA: begin
            if (rd_vld_ff && !done_ff[rd_idx_ff] && ({1'b0, rd_arrival} < early_ff)) begin
               early_in = {1'b0, rd_arrival};
            end
            if (scan_ff < count_ff) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               state_in = StScanB;
               now_in   = now_pick;
               scan_in  = '0;
               found_in = 1'b0;
            end
         end
         // choose among arrived jobs
         StScanB: begin
            if (cand && (!found_ff || better)) begin
               found_in    = 1'b1;
               best_in     = rd_idx_ff;
               best_arr_in = rd_arrival;
               best_svc_in = rd_service;
            end
            if (scan_ff < count_ff) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               state_in = StRun;
            end
         end
         StRun: begin
            fin_in = (fin_sum > {1'b0, TimeMax}) ? TimeMax : fin_sum[13:0];
            state_in = StRead;
         end
         StRead: begin
            ta_in = fin_ff - {2'b00, best_arr_ff};
            div_req.start    = 1'b1;
            div_req.dividend = {8'd0, fin_ff - {2'b00, best_arr_ff}, 8'd0};
            div_req.divisor  = best_svc_ff;
            state_in = StWt;
         end
         StWt: begin
            if (div_rsp.done) begin
               wt_in   = div_rsp.quotient[21:0];
               tsum_in = tsum_ff + {6'd0, ta_ff};
               wsum_in = wsum_ff + {6'd0, div_rsp.quotient[21:0]};
               done_in[best_ff] = 1'b1;
               now_in  = fin_ff;
               emitted_in = emitted_ff + CW'(1);
               if (emitted_ff + CW'(1) == count_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {2'b00, tsum_ff + {6'd0, ta_ff}, 8'd0};
                  div_req.divisor  = 8'(count_ff);
                  state_in = StAvgT;
               end else begin
                  state_in = StOut;
               end
            end
         end
         StAvgT: begin
            if (div_rsp.done) begin
               avgt_in = div_rsp.quotient[21:0];
               div_req.start    = 1'b1;
               div_req.dividend = {2'b00, wsum_ff};
               div_req.divisor  = 8'(count_ff);
               state_in = StAvgW;
            end
         end
         StAvgW: begin
            if (div_rsp.done) begin
               state_in = StOut;
            end
         end
         StOut: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.job_index           = 6'(best_ff);
               rsp_in.start_time          = start_ff;
               rsp_in.finish_time         = fin_ff;
               rsp_in.turnaround          = ta_ff;
               rsp_in.weighted_turnaround = wt_ff;
               rsp_in.overflow            = ovf_ff;
               rsp_in.last_result         = (emitted_ff == count_ff);
               rsp_in.average_turnaround  = '0;
               rsp_in.average_weighted    = '0;
               if (emitted_ff == count_ff) begin
                  rsp_in.average_turnaround = avgt_ff;
                  rsp_in.average_weighted   = div_rsp.quotient[21:0];
                  state_in = StLoad;
                  count_in = '0;
                  now_in   = '0;
                  tsum_in  = '0;
                  wsum_in  = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in = StScanA;
                  scan_in  = '0;
                  early_in = 13'h1fff;
               end
            end
         end
         default: state_in = StLoad;
      endcase
   end

   // start tick is kept alongside the finish for saturated finishes
   assign start_in = (state_ff == StRun) ? now_ff : start_ff;

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      early_ff    <= early_in;
      best_ff     <= best_in;
      best_arr_ff <= best_arr_in;
      best_svc_ff <= best_svc_in;
      fin_ff      <= fin_in;
      ta_ff       <= ta_in;
      wt_ff       <= wt_in;
      avgt_ff     <= avgt_in;
      rsp_ff      <= rsp_in;
      start_ff    <= start_in;
      found_ff    <= found_in;
      emitted_ff  <= emitted_in;
      if (reset) begin
         state_ff     <= StLoad;
         policy_ff    <= PolicyFcfs;
         count_ff     <= '0;
         now_ff       <= '0;
         tsum_ff      <= '0;
         wsum_ff      <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write) begin
            policy_ff <= csr_policy;
         end
         count_ff     <= count_in;
         now_ff       <= now_in;
         tsum_ff      <= tsum_in;
         wsum_ff      <= wsum_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/bjs_checker.sv
module bjs_checker
   import bjs_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

`include "batch_job_scheduler_metrics_assert.svh"

   `BJS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")
   `BJS_ASSERT_IMPL(a_fin_order, clock, reset, rsp_valid, rsp_payload.finish_time >= rsp_payload.start_time, "finish before start")
   `BJS_ASSERT_IMPL(a_avg_zero, clock, reset, rsp_valid && !rsp_payload.last_result, rsp_payload.average_turnaround == '0 && rsp_payload.average_weighted == '0, "average on inner result")
   `BJS_ASSERT_IMPL(a_busy_out, clock, reset, rsp_valid && !rsp_payload.last_result, req_stall, "inner result shown while loading")

endmodule

bind batch_job_scheduler_metrics bjs_checker u_bjs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

### tb/batch_job_scheduler_metrics_tb.sv
module batch_job_scheduler_metrics_tb;
   import bjs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 32;
   localparam int MaxMiss = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_policy = PolicyFcfs;

   batch_job_scheduler_metrics #(.MAX_JOBS(Depth)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_policy(csr_policy)
   );

   always #1 clock = ~clock;

   // scheduler shadow state
   logic [1:0] sched_policy;
   logic [11:0] arr_mem [Depth];
   logic [7:0] svc_mem [Depth];
   bit ran [Depth];
   int unsigned jobs_held;
   bit dropped;
   rsp_payload_type pending_results[$];
   int miss_count = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit check_fixed;
   rsp_payload_type fixed_result;

   typedef struct {
      logic [11:0] arrival;
      logic [7:0] service;
      bit last;
      bit fixed;
      logic [21:0] weighted;
      logic [21:0] avg_turn;
   } beat_row_type;

   function automatic bit wins(int a, int b, int unsigned now);
      longint unsigned sa, sb, ra, rb;
      sa = svc_mem[a];
      sb = svc_mem[b];
      if (sched_policy == PolicySjf) begin
         if (sa != sb) return sa < sb;
      end else if (sched_policy == PolicyHrrn) begin
         ra = (longint'(now) - arr_mem[a] + sa) * sb;
         rb = (longint'(now) - arr_mem[b] + sb) * sa;
         if (ra != rb) return ra > rb;
      end
      return arr_mem[a] < arr_mem[b];
   endfunction

   task automatic schedule_batch();
      int unsigned now, earliest, fin, turn, wt, turn_sum, wt_sum;
      int best;
      rsp_payload_type r;
      now = 0;
      turn_sum = 0;
      wt_sum = 0;
      for (int k = 0; k < jobs_held; k++) begin
         earliest = 32'hffff_ffff;
         for (int i = 0; i < jobs_held; i++)
            if (!ran[i] && arr_mem[i] < earliest) earliest = arr_mem[i];
         if (earliest > now) now = earliest;
         best = -1;
         for (int i = 0; i < jobs_held; i++) begin
            if (ran[i] || arr_mem[i] > now) continue;
            if (best < 0 || wins(i, best, now)) best = i;
         end
         fin = now + svc_mem[best];
         if (fin > TimeMax) fin = TimeMax;
         turn = fin - arr_mem[best];
         wt = (turn << 8) / svc_mem[best];
         turn_sum += turn;
         wt_sum += wt;
         r = '0;
         r.job_index = best[5:0];
         r.start_time = now[13:0];
         r.finish_time = fin[13:0];
         r.turnaround = turn[13:0];
         r.weighted_turnaround = wt[21:0];
         r.overflow = dropped;
         if (k + 1 == jobs_held) begin
            r.average_turnaround = 22'((turn_sum << 8) / jobs_held);
            r.average_weighted = 22'(wt_sum / jobs_held);
            r.last_result = 1'b1;
         end
         ran[best] = 1'b1;
         now = fin;
         pending_results.push_back(r);
      end
      jobs_held = 0;
      dropped = 0;
      for (int i = 0; i < Depth; i++) ran[i] = 0;
   endtask

   task automatic load_beat(req_payload_type p);
      logic [7:0] s;
      s = (p.service_time == 0) ? 8'd1 : p.service_time;
      if (jobs_held < Depth) begin
         arr_mem[jobs_held] = p.arrival_time;
         svc_mem[jobs_held] = s;
         ran[jobs_held] = 0;
         jobs_held++;
      end else begin
         dropped = 1;
      end
      if (p.last_job) schedule_batch();
   endtask

   task automatic send_beat(logic [11:0] a, logic [7:0] s, bit l);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= '{arrival_time: a, service_time: s, last_job: l};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_beat('{arrival_time: a, service_time: s, last_job: l});
      @(negedge clock);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic set_policy(logic [1:0] p);
      drain_wait();
      csr_policy <= p;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      sched_policy = p;
   endtask

   always @(negedge clock) rsp_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            miss_count++;
            if (miss_count <= MaxMiss) $display("unexpected beat %p", rsp_payload);
         end else begin
            want = pending_results.pop_front();
            if (check_fixed && want.last_result) begin
               if (rsp_payload.weighted_turnaround !== fixed_result.weighted_turnaround
                   || rsp_payload.average_turnaround !== fixed_result.average_turnaround) begin
                  miss_count++;
                  if (miss_count <= MaxMiss)
                     $display("mismatch: expected %p actual %p", fixed_result, rsp_payload);
               end
               check_fixed = 0;
            end
            if (rsp_payload !== want) begin
               miss_count++;
               if (miss_count <= MaxMiss)
                  $display("mismatch: expected %p actual %p", want, rsp_payload);
            end
         end
      end
   end

   beat_row_type rows [13] = '{
      '{12'd0, 8'd1, 1, 1, 22'd256, 22'd256},
      '{12'd4095, 8'd255, 1, 1, 22'd256, 22'd65280},
      '{12'd0, 8'd0, 1, 1, 22'd256, 22'd256},
      '{12'd10, 8'd5, 0, 0, 0, 0},
      '{12'd0, 8'd20, 0, 0, 0, 0},
      '{12'd0, 8'd3, 0, 0, 0, 0},
      '{12'd100, 8'd7, 0, 0, 0, 0},
      '{12'd2, 8'd3, 1, 0, 0, 0},
      '{12'd4095, 8'd255, 0, 0, 0, 0},
      '{12'd4095, 8'd255, 0, 0, 0, 0},
      '{12'd4000, 8'd128, 1, 0, 0, 0},
      '{12'd5, 8'd1, 0, 0, 0, 0},
      '{12'd5, 8'd1, 1, 0, 0, 0}
   };

   task automatic random_batch(int n, bit heavy);
      for (int i = 0; i < n; i++)
         send_beat(heavy ? 12'($urandom_range(4095)) : 12'($urandom_range(300)),
                   8'($urandom_range(255)), i == n - 1);
   endtask

   task automatic directed_pass();
      foreach (rows[i]) begin
         if (rows[i].fixed) begin
            if (pending_results.size() != 0) begin
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(negedge clock);
            end
            fixed_result = '0;
            fixed_result.weighted_turnaround = rows[i].weighted;
            fixed_result.average_turnaround = rows[i].avg_turn;
            check_fixed = 1;
         end
         send_beat(rows[i].arrival, rows[i].service, rows[i].last);
      end
   endtask

   initial begin
      sched_policy = PolicyFcfs;
      jobs_held = 0;
      dropped = 0;
      check_fixed = 0;
      for (int i = 0; i < Depth; i++) ran[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_pass();
      for (int p = PolicySjf; p <= 3; p++) begin
         set_policy(2'(p));
         directed_pass();
      end
      // overflow: 34 jobs into 32 entries
      random_batch(34, 1);
      for (int phase = 0; phase < 8; phase++) begin
         set_policy(2'(phase % 4));
         case (phase % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 51; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 51; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         for (int b = 0; b < 8; b++)
            random_batch($urandom_range(1, 8), $urandom_range(3) == 0);
         if (phase == 4) begin
            drain_wait();
            random_batch(32, 1);
         end
      end
      send_idle = 0;
      recv_stall = 0;
      drain_wait();
      if (miss_count == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
